// File: sv/olid_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list insert/delete package
// Shared widths, request and status codes, and the cell control types.
// ----------------------------------------------------------------------------
package olid_pkg;

    // Width of one list entry and of the request value.
    localparam int DATA_W = 32;

    // Default number of cells in the list.
    localparam int LIST_DEPTH_DEF = 16;

    // Request codes carried by req_type.
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_PUSH   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_DUMP   = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Operation broadcast to every cell in the same cycle.
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_APPEND = 3'd1,
        CELL_PUSH   = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_ROTATE = 3'd4
    } cell_op_t;

    // Control bundle from the sequencer to the cell row.
    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// File: sv/olid_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one list request per transaction.
// ----------------------------------------------------------------------------
interface olid_req_if;

    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic signed [olid_pkg::DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);

endinterface

// File: sv/olid_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result item per transaction.
// ----------------------------------------------------------------------------
interface olid_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [olid_pkg::DATA_W-1:0] data_out;
    logic                              last;

    modport source (output valid, output status, output data_out, output last,
                    input ready);
    modport sink   (input valid, input status, input data_out, input last,
                    output ready);

endinterface

// File: sv/ordered_list_insert_delete_core.sv
// An append, push or delete gives its single result in the cycle after it is accepted.
// Throughput: one append, push or delete per cycle while results are taken.
// A dump of N entries (N > 0) gives one entry per cycle while results are taken, from the
// rotating cell row; a dump of an empty list behaves like a single-result request.
// Reset clears the entry count and the result register; cell contents are left as they are.
// ----------------------------------------------------------------------------
// Ordered list insert/delete core
// Sequencer, entry count and result register around a row of list cells.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core #(
    parameter int LIST_DEPTH = olid_pkg::LIST_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    olid_req_if.sink     req,
    olid_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                             state_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   remain_reg;
    logic                               out_valid_reg;
    olid_pkg::status_t                  out_status_reg;
    logic signed [olid_pkg::DATA_W-1:0] out_data_reg;
    logic                               out_last_reg;

    olid_pkg::cell_ctrl_t               ctrl;
    olid_pkg::req_t                     req_code;
    logic signed [olid_pkg::DATA_W-1:0] head_data;
    logic                               found;
    logic                               out_free;
    logic                               accept;
    logic                               full;

    // Handshake and list status.
    assign req_code  = olid_pkg::req_t'(req.req_type);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == CNT_W'(LIST_DEPTH);

    // Operation broadcast to the cell row.
    always_comb
    begin
        ctrl.op    = olid_pkg::CELL_HOLD;
        ctrl.value = req.value;
        if (accept)
        begin
            unique case (req_code)
                olid_pkg::REQ_APPEND:
                begin
                    if (!full)
                    begin
                        ctrl.op = olid_pkg::CELL_APPEND;
                    end
                end
                olid_pkg::REQ_PUSH:
                begin
                    if (!full)
                    begin
                        ctrl.op = olid_pkg::CELL_PUSH;
                    end
                end
                olid_pkg::REQ_DELETE:
                begin
                    ctrl.op = olid_pkg::CELL_DELETE;
                end
                olid_pkg::REQ_DUMP:
                begin
                    ctrl.op = olid_pkg::CELL_HOLD;
                end
                default:
                begin
                    ctrl.op = olid_pkg::CELL_HOLD;
                end
            endcase
        end
        else if ((state_reg == S_DUMP) && out_free)
        begin
            ctrl.op = olid_pkg::CELL_ROTATE;
        end
    end

    olid_cell_row #(
        .LIST_DEPTH (LIST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_row (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count_reg),
        .head_data (head_data),
        .found     (found)
    );

    // Sequencer, entry count and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= olid_pkg::ST_OK;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req_code)
                            olid_pkg::REQ_APPEND, olid_pkg::REQ_PUSH:
                            begin
                                out_valid_reg <= 1'b1;
                                out_data_reg  <= '0;
                                out_last_reg  <= 1'b1;
                                if (full)
                                begin
                                    out_status_reg <= olid_pkg::ST_FULL;
                                end
                                else
                                begin
                                    out_status_reg <= olid_pkg::ST_OK;
                                    count_reg      <= count_reg + 1'b1;
                                end
                            end
                            olid_pkg::REQ_DELETE:
                            begin
                                out_valid_reg <= 1'b1;
                                out_last_reg  <= 1'b1;
                                if (found)
                                begin
                                    out_status_reg <= olid_pkg::ST_OK;
                                    out_data_reg   <= req.value;
                                    count_reg      <= count_reg - 1'b1;
                                end
                                else
                                begin
                                    out_status_reg <= olid_pkg::ST_NOTFOUND;
                                    out_data_reg   <= '0;
                                end
                            end
                            olid_pkg::REQ_DUMP:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= olid_pkg::ST_EMPTY;
                                    out_data_reg   <= '0;
                                    out_last_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg  <= S_DUMP;
                                    remain_reg <= count_reg;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DUMP:
                begin
                    // Emit the head and rotate it to the tail in the same cycle.
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= olid_pkg::ST_OK;
                        out_data_reg   <= head_data;
                        out_last_reg   <= remain_reg == CNT_W'(1);
                        remain_reg     <= remain_reg - 1'b1;
                        if (remain_reg == CNT_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.data_out = out_data_reg;
    assign rsp.last     = out_last_reg;

endmodule

// File: sv/olid_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry, compares it with the request value and takes data
// from its left or right neighbour according to the broadcast operation.
// ----------------------------------------------------------------------------
module olid_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic                               clk,
    input  olid_pkg::cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]                   count,
    input  logic signed [olid_pkg::DATA_W-1:0] left_data,
    input  logic signed [olid_pkg::DATA_W-1:0] right_data,
    input  logic signed [olid_pkg::DATA_W-1:0] head_data,
    input  logic                               hit_in,
    output logic signed [olid_pkg::DATA_W-1:0] data,
    output logic                               hit_out
);

    logic signed [olid_pkg::DATA_W-1:0] data_reg;
    logic signed [olid_pkg::DATA_W-1:0] data_next;
    logic                               occupied;
    logic                               is_free_slot;
    logic                               is_tail;

    // Position of this cell relative to the current fill level.
    assign occupied     = CNT_W'(INDEX) < count;
    assign is_free_slot = CNT_W'(INDEX) == count;
    assign is_tail      = CNT_W'(INDEX + 1) == count;

    // A match at or before this cell means the cell closes the gap.
    assign hit_out = hit_in || (occupied && (data_reg == ctrl.value));

    // Next entry value for the broadcast operation.
    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            olid_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            olid_pkg::CELL_APPEND:
            begin
                if (is_free_slot)
                begin
                    data_next = ctrl.value;
                end
            end
            olid_pkg::CELL_PUSH:
            begin
                data_next = left_data;
            end
            olid_pkg::CELL_DELETE:
            begin
                if (hit_out)
                begin
                    data_next = right_data;
                end
            end
            olid_pkg::CELL_ROTATE:
            begin
                data_next = is_tail ? head_data : right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Entry storage; contents are meaningless until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: sv/olid_cell_row.sv
// ----------------------------------------------------------------------------
// Cell row
// Chains the list cells head to tail, wiring neighbour data and the
// first-match chain, and reports whether a delete found its value.
// ----------------------------------------------------------------------------
module olid_cell_row #(
    parameter int LIST_DEPTH = olid_pkg::LIST_DEPTH_DEF,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  logic                               clk,
    input  olid_pkg::cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]                   count,
    output logic signed [olid_pkg::DATA_W-1:0] head_data,
    output logic                               found
);

    logic signed [olid_pkg::DATA_W-1:0] cell_data [LIST_DEPTH];
    logic [LIST_DEPTH:0]                hit_chain;

    // No match can precede the head cell.
    assign hit_chain[0] = 1'b0;

    // One cell per list position.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic signed [olid_pkg::DATA_W-1:0] left_data;
        logic signed [olid_pkg::DATA_W-1:0] right_data;

        // The head takes the new value on a push; the last cell keeps its own
        // value when the row shifts towards the head.
        if (i == 0)
        begin : g_head
            assign left_data = ctrl.value;
        end
        else
        begin : g_body
            assign left_data = cell_data[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_end
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner
            assign right_data = cell_data[i+1];
        end

        olid_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count),
            .left_data  (left_data),
            .right_data (right_data),
            .head_data  (cell_data[0]),
            .hit_in     (hit_chain[i]),
            .data       (cell_data[i]),
            .hit_out    (hit_chain[i+1])
        );
    end

    assign head_data = cell_data[0];
    assign found     = hit_chain[LIST_DEPTH];

endmodule

// File: sv/olid_checker.sv
// ----------------------------------------------------------------------------
// Ordered list port checker
// Watches the request and result channels of the core and flags sequences
// that the list must never show.
// ----------------------------------------------------------------------------
module olid_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic [1:0]                         req_type,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [1:0]                         rsp_status,
    input logic signed [olid_pkg::DATA_W-1:0] rsp_data,
    input logic                               rsp_last
);

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_status) && $stable(rsp_data) && $stable(rsp_last))
    else $error("Stalled result changed");

    // Any request other than a dump gives its single result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type != olid_pkg::REQ_DUMP) |=>
            rsp_valid && rsp_last)
    else $error("Single-result request did not produce a last result");

    // No new request is taken while a dump is part-way through.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
    else $error("Request accepted during a dump");

    // Error results carry zero data and close their transaction group.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != olid_pkg::ST_OK) |-> (rsp_data == '0) && rsp_last)
    else $error("Error result with data or without last");

endmodule

bind ordered_list_insert_delete_core olid_checker u_olid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_data   (rsp.data_out),
    .rsp_last   (rsp.last)
);
